>>> hdl/frdr_pkg.sv
package frdr_pkg;

  localparam int COS_FRAC_BITS = 15;
  localparam int ETA_FRAC_BITS = 12;

  localparam int ROOT_STEPS = 16;
  localparam int DIV_STEPS  = COS_FRAC_BITS + 1;

  localparam logic [15:0] COS_ONE = 16'(1 << COS_FRAC_BITS);
  localparam logic [31:0] RAD_ONE = 32'(1) << (2 * COS_FRAC_BITS);

  typedef struct packed {
    logic [15:0] cos_incident;
    logic [15:0] eta_incident;
    logic [15:0] eta_transmitted;
  } frdr_req_t;

  typedef struct packed {
    logic [15:0] reflectance;
    logic        total_internal;
  } frdr_res_t;

  typedef struct packed {
    logic [15:0] c;
    logic [15:0] ei;
    logic [15:0] et;
    logic        tir;
  } frdr_side_t;

endpackage

>>> hdl/frdr_isqrt.sv
module frdr_isqrt (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [31:0]       radicand,
  input  frdr_pkg::frdr_side_t in_side,
  output logic              out_valid,
  output logic [15:0]       root,
  output frdr_pkg::frdr_side_t out_side
);
  import frdr_pkg::*;

  logic        vld_q  [ROOT_STEPS];
  logic [15:0] root_q [ROOT_STEPS];
  logic [16:0] rem_q  [ROOT_STEPS];
  logic [31:0] rad_q  [ROOT_STEPS];
  frdr_side_t  side_q [ROOT_STEPS];

  for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_step
    logic        p_vld;
    logic [15:0] p_root;
    logic [16:0] p_rem;
    logic [31:0] p_rad;
    frdr_side_t  p_side;
    logic [18:0] rem_sh;
    logic [18:0] trial;
    logic        take;

    if (k == 0) begin : g_first
      assign p_vld  = in_valid;
      assign p_root = '0;
      assign p_rem  = '0;
      assign p_rad  = radicand;
      assign p_side = in_side;
    end else begin : g_rest
      assign p_vld  = vld_q[k-1];
      assign p_root = root_q[k-1];
      assign p_rem  = rem_q[k-1];
      assign p_rad  = rad_q[k-1];
      assign p_side = side_q[k-1];
    end

    always_comb begin
      rem_sh = {p_rem, p_rad[31:30]};
      trial  = {1'b0, p_root, 2'b01};
      take   = (rem_sh >= trial);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= p_vld;
      end
      root_q[k] <= {p_root[14:0], take};
      rem_q[k]  <= take ? 17'(rem_sh - trial) : rem_sh[16:0];
      rad_q[k]  <= {p_rad[29:0], 2'b00};
      side_q[k] <= p_side;
    end
  end

  assign out_valid = vld_q[ROOT_STEPS-1];
  assign root      = root_q[ROOT_STEPS-1];
  assign out_side  = side_q[ROOT_STEPS-1];

endmodule

>>> hdl/frdr_div.sv
module frdr_div (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [33:0]       rem_init,
  input  logic [14:0]       low_bits,
  input  logic [32:0]       divisor,
  input  frdr_pkg::frdr_side_t in_side,
  output logic              out_valid,
  output logic [15:0]       quotient,
  output frdr_pkg::frdr_side_t out_side
);
  import frdr_pkg::*;

  logic        vld_q  [DIV_STEPS];
  logic [15:0] quo_q  [DIV_STEPS];
  logic [33:0] rem_q  [DIV_STEPS];
  logic [14:0] low_q  [DIV_STEPS];
  logic [32:0] den_q  [DIV_STEPS];
  frdr_side_t  side_q [DIV_STEPS];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic        p_vld;
    logic [15:0] p_quo;
    logic [33:0] p_rem;
    logic [14:0] p_low;
    logic [32:0] p_den;
    frdr_side_t  p_side;
    logic        take;
    logic [33:0] diff;

    if (k == 0) begin : g_first
      assign p_vld  = in_valid;
      assign p_quo  = '0;
      assign p_rem  = rem_init;
      assign p_low  = low_bits;
      assign p_den  = divisor;
      assign p_side = in_side;
    end else begin : g_rest
      assign p_vld  = vld_q[k-1];
      assign p_quo  = quo_q[k-1];
      assign p_rem  = rem_q[k-1];
      assign p_low  = low_q[k-1];
      assign p_den  = den_q[k-1];
      assign p_side = side_q[k-1];
    end

    always_comb begin
      take = (p_rem >= {1'b0, p_den});
      diff = take ? (p_rem - {1'b0, p_den}) : p_rem;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= p_vld;
      end
      quo_q[k]  <= {p_quo[14:0], take};
      rem_q[k]  <= {diff[32:0], p_low[14]};
      low_q[k]  <= {p_low[13:0], 1'b0};
      den_q[k]  <= p_den;
      side_q[k] <= p_side;
    end
  end

  assign out_valid = vld_q[DIV_STEPS-1];
  assign quotient  = quo_q[DIV_STEPS-1];
  assign out_side  = side_q[DIV_STEPS-1];

endmodule

>>> hdl/fresnel_dielectric_reflectance_unit.sv
// Fresnel reflectance, unpolarised, smooth dielectric boundary.
// Throughput: one word per cycle; busy stays low, no stall anywhere.
// Depth set by two 16-step root pipes and two 16-step divider pipes in series.
// Synchronous reset clears all stage valid bits; payload is not reset.
module fresnel_dielectric_reflectance_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  frdr_pkg::frdr_req_t request,
  output logic                done,
  output frdr_pkg::frdr_res_t result
);
  import frdr_pkg::*;

  // s0: clamp cosine
  logic        v0;
  frdr_side_t  sd0;
  // s1: radicand for sinI
  logic        v1;
  logic [31:0] rad1;
  frdr_side_t  sd1;
  logic        vr1;
  logic [15:0] sin_i;
  frdr_side_t  sdr1;
  // s2: Snell product
  logic        v2;
  logic [31:0] prod;
  frdr_side_t  sd2;
  logic        vd1;
  logic [15:0] q_sin;
  frdr_side_t  sdd1;
  // s3: radicand for cosT
  logic        v3;
  logic [31:0] rad2;
  frdr_side_t  sd3;
  logic [15:0] sin_t;
  logic        vr2;
  logic [15:0] cos_t;
  frdr_side_t  sdr2;
  // s4: products
  logic        v4;
  logic [31:0] p_tc, p_ic_t, p_ic, p_tc_t;
  frdr_side_t  sd4;
  // s5: ratio terms
  logic        v5;
  logic [32:0] num_p, den_p, num_s, den_s;
  frdr_side_t  sd5;
  logic        vd2;
  logic [15:0] q_par, q_perp;
  frdr_side_t  sdd2;
  logic        vd_perp;
  frdr_side_t  sdd_perp;
  // s6: squares
  logic        v6;
  logic [31:0] sq_par, sq_perp;
  logic        forced6;
  logic [32:0] sq_sum;
  logic [16:0] r_raw;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      done <= 1'b0;
    end else begin
      v0 <= start && !busy;
      v1 <= v0;
      v2 <= vr1;
      v3 <= vd1;
      v4 <= vr2;
      v5 <= v4;
      v6 <= vd2;
      done <= v6;
    end

    sd0.c   <= (request.cos_incident > COS_ONE) ? COS_ONE : request.cos_incident;
    sd0.ei  <= request.eta_incident;
    sd0.et  <= request.eta_transmitted;
    sd0.tir <= 1'b0;

    rad1 <= RAD_ONE - 32'(sd0.c * sd0.c);
    sd1  <= sd0;

    prod <= 32'(sdr1.ei * sin_i);
    sd2  <= '{c: sdr1.c, ei: sdr1.ei, et: sdr1.et,
              tir: (32'(sdr1.ei * sin_i) > {1'b0, sdr1.et, 15'b0})};

    rad2 <= RAD_ONE - 32'(sin_t * sin_t);
    sd3  <= sdd1;

    p_tc   <= 32'(sdr2.et * sdr2.c);
    p_ic_t <= 32'(sdr2.ei * cos_t);
    p_ic   <= 32'(sdr2.ei * sdr2.c);
    p_tc_t <= 32'(sdr2.et * cos_t);
    sd4    <= sdr2;

    num_p <= (p_tc >= p_ic_t) ? 33'(p_tc - p_ic_t) : 33'(p_ic_t - p_tc);
    den_p <= 33'(p_tc) + 33'(p_ic_t);
    num_s <= (p_ic >= p_tc_t) ? 33'(p_ic - p_tc_t) : 33'(p_tc_t - p_ic);
    den_s <= 33'(p_ic) + 33'(p_tc_t);
    sd5   <= '{c: sd4.c, ei: sd4.ei, et: sd4.et,
              tir: sd4.tir || ((33'(p_tc) + 33'(p_ic_t)) == '0)
                   || ((33'(p_ic) + 33'(p_tc_t)) == '0)};

    sq_par  <= 32'(q_par * q_par);
    sq_perp <= 32'(q_perp * q_perp);
    forced6 <= sdd2.tir;

    if (forced6) begin
      result.reflectance    <= COS_ONE;
      result.total_internal <= 1'b1;
    end else begin
      result.reflectance    <= (r_raw > 17'(COS_ONE)) ? COS_ONE : r_raw[15:0];
      result.total_internal <= 1'b0;
    end
  end

  always_comb begin
    if (sdd1.et == '0) begin
      sin_t = '0;
    end else begin
      sin_t = (q_sin > COS_ONE) ? COS_ONE : q_sin;
    end
    sq_sum = 33'(sq_par) + 33'(sq_perp);
    r_raw  = sq_sum[32:16];
  end

  frdr_isqrt u_sqrt_sin (
    .clk(clk), .rst(rst),
    .in_valid(v1), .radicand(rad1), .in_side(sd1),
    .out_valid(vr1), .root(sin_i), .out_side(sdr1)
  );

  frdr_div u_div_snell (
    .clk(clk), .rst(rst),
    .in_valid(v2), .rem_init({17'b0, prod[31:15]}), .low_bits(prod[14:0]),
    .divisor({17'b0, sd2.et}), .in_side(sd2),
    .out_valid(vd1), .quotient(q_sin), .out_side(sdd1)
  );

  frdr_isqrt u_sqrt_cos (
    .clk(clk), .rst(rst),
    .in_valid(v3), .radicand(rad2), .in_side(sd3),
    .out_valid(vr2), .root(cos_t), .out_side(sdr2)
  );

  frdr_div u_div_par (
    .clk(clk), .rst(rst),
    .in_valid(v5), .rem_init({1'b0, num_p}), .low_bits('0),
    .divisor(den_p), .in_side(sd5),
    .out_valid(vd2), .quotient(q_par), .out_side(sdd2)
  );

  frdr_div u_div_perp (
    .clk(clk), .rst(rst),
    .in_valid(v5), .rem_init({1'b0, num_s}), .low_bits('0),
    .divisor(den_s), .in_side(sd5),
    .out_valid(vd_perp), .quotient(q_perp), .out_side(sdd_perp)
  );

  a_forced_one: assert property (@(posedge clk) disable iff (rst)
    done && result.total_internal |-> result.reflectance == COS_ONE)
    else $error("forced word not one");

  a_sat: assert property (@(posedge clk) disable iff (rst)
    done |-> result.reflectance <= COS_ONE)
    else $error("reflectance above one");

  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(v6))
    else $error("done without stage valid");

  a_div_align: assert property (@(posedge clk) disable iff (rst)
    vd2 |-> $past(v5, DIV_STEPS))
    else $error("divider valid misaligned");

  a_lanes: assert property (@(posedge clk) disable iff (rst)
    (vd2 == vd_perp) && (!vd2 || sdd2 == sdd_perp))
    else $error("ratio lanes out of step");

endmodule
